### rtl/psnap_pkg.sv
package psnap_pkg;

  localparam int NODES  = 4096;
  localparam int PAGES  = 1024;
  localparam int NODE_W = $clog2(NODES);
  localparam int PAGE_W = $clog2(PAGES);
  localparam int VAL_W  = 31;
  localparam int MODE_W = 2;

  localparam int IN_DATA_W  = ((VAL_W + PAGE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SAVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd3;

  typedef logic [NODE_W-1:0] node_ptr_t;
  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [VAL_W-1:0]  value_t;

  typedef struct packed {
    node_ptr_t parent;
    value_t    value;
  } node_t;

endpackage

### rtl/psnap_node_mem.sv
module psnap_node_mem (
  input  logic                clk,
  input  logic                we,
  input  psnap_pkg::node_ptr_t waddr,
  input  psnap_pkg::node_t    wdata,
  input  logic                re,
  input  psnap_pkg::node_ptr_t raddr,
  output psnap_pkg::node_t    rdata
);

  psnap_pkg::node_t mem [psnap_pkg::NODES];
  psnap_pkg::node_t rd_q;
  logic             rd_zero;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q    <= mem[raddr];
      rd_zero <= (raddr == '0);
    end
  end

  // node 0 is the empty stack: value and parent read as zero
  assign rdata = rd_zero ? '0 : rd_q;

endmodule

### rtl/psnap_page_mem.sv
module psnap_page_mem (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  psnap_pkg::page_t     waddr,
  input  psnap_pkg::node_ptr_t wdata,
  input  logic                 re,
  input  psnap_pkg::page_t     raddr,
  output psnap_pkg::node_ptr_t rdata,
  output logic                 busy
);

  psnap_pkg::node_ptr_t mem [psnap_pkg::PAGES];
  psnap_pkg::node_ptr_t rd_q;
  psnap_pkg::page_t     clr_addr;
  logic                 clearing;
  psnap_pkg::page_t     wa;
  psnap_pkg::node_ptr_t wd;
  logic                 wen;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == psnap_pkg::PAGE_W'(psnap_pkg::PAGES - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + psnap_pkg::page_t'(1);
    end
  end

  always_comb begin
    wa  = clearing ? clr_addr : waddr;
    wd  = clearing ? '0 : wdata;
    wen = clearing | we;
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  assign rdata = rd_q;
  assign busy  = clearing;

endmodule

### rtl/persistent_stack_snapshot.sv
// persistent stack with snapshot pages
// input words arrive on s_tvalid/s_tready: s_tuser holds the mode (push, pop,
// save, load), s_tdata the push value and the page index. every input word
// gives exactly one output word on m_tvalid/m_tready: the top value after the
// operation in m_tdata, the empty flag and the dropped-push flag in m_tuser.
// the block takes one word at a time; after acceptance push and save go
// straight to the hold state, pop first reads the node store, and load reads
// the page table and then the node store, before the result is written to
// the output register and the block returns to idle.
// a finished word waits in the output register while the next input word is
// taken; if the receiver stalls with a word still waiting, the next result
// is held and s_tready stays low until the output register frees up.
// after rst the page table is swept to zero, all 1024 entries, one entry per
// cycle; s_tready stays low during the sweep. the stack starts empty and
// the node store is allocated upward from node 1; a push once 4095 nodes are
// in use is dropped and flagged.
module persistent_stack_snapshot (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // value [30:0], page [40:31], zero fill
  input  logic [psnap_pkg::IN_DATA_W-1:0]      s_tdata,
  // mode [1:0]
  input  logic [psnap_pkg::MODE_W-1:0]         s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // top_value [30:0], zero fill
  output logic [psnap_pkg::OUT_DATA_W-1:0]     m_tdata,
  // is_empty [0], store_full [1]
  output logic [psnap_pkg::OUT_USER_W-1:0]     m_tuser
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PAGE = 2'd1;
  localparam logic [1:0] ST_NODE = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]           state;
  psnap_pkg::node_ptr_t top;
  psnap_pkg::node_ptr_t top_par;
  psnap_pkg::value_t    top_val;
  psnap_pkg::node_ptr_t node_count;
  logic                 full;

  logic                       accept;
  logic [psnap_pkg::MODE_W-1:0] in_mode;
  psnap_pkg::value_t          in_value;
  psnap_pkg::page_t           in_page;
  logic                       can_push;
  psnap_pkg::node_ptr_t       new_node;
  logic                       hold_load;

  logic                 node_we;
  psnap_pkg::node_t     node_wdata;
  logic                 node_re;
  psnap_pkg::node_ptr_t node_raddr;
  psnap_pkg::node_t     node_rdata;

  logic                 page_we;
  logic                 page_re;
  psnap_pkg::node_ptr_t page_rdata;
  logic                 page_busy;

  assign in_mode  = s_tuser;
  assign in_value = s_tdata[psnap_pkg::VAL_W-1:0];
  assign in_page  = s_tdata[psnap_pkg::VAL_W +: psnap_pkg::PAGE_W];

  assign s_tready  = (state == ST_IDLE) && !page_busy;
  assign accept    = s_tvalid && s_tready;
  assign can_push  = (node_count != psnap_pkg::NODE_W'(psnap_pkg::NODES - 1));
  assign new_node  = node_count + psnap_pkg::node_ptr_t'(1);
  assign hold_load = (state == ST_HOLD) && (!m_tvalid || m_tready);

  always_comb begin
    node_we           = accept && (in_mode == psnap_pkg::MODE_PUSH) && can_push;
    node_wdata.parent = top;
    node_wdata.value  = in_value;
    node_re           = (accept && (in_mode == psnap_pkg::MODE_POP)) || (state == ST_PAGE);
    node_raddr        = (state == ST_PAGE) ? page_rdata : top_par;
    page_we           = accept && (in_mode == psnap_pkg::MODE_SAVE);
    page_re           = accept && (in_mode == psnap_pkg::MODE_LOAD);
  end

  psnap_node_mem u_node_mem (
    .clk   (clk),
    .we    (node_we),
    .waddr (new_node),
    .wdata (node_wdata),
    .re    (node_re),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  psnap_page_mem u_page_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (page_we),
    .waddr (in_page),
    .wdata (top),
    .re    (page_re),
    .raddr (in_page),
    .rdata (page_rdata),
    .busy  (page_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      top        <= '0;
      top_par    <= '0;
      top_val    <= '0;
      node_count <= '0;
      full       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !hold_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            full <= (in_mode == psnap_pkg::MODE_PUSH) && !can_push;
            case (in_mode)
              psnap_pkg::MODE_PUSH: begin
                if (can_push) begin
                  node_count <= new_node;
                  top        <= new_node;
                  top_par    <= top;
                  top_val    <= in_value;
                end
                state <= ST_HOLD;
              end
              psnap_pkg::MODE_POP: begin
                top   <= top_par;
                state <= ST_NODE;
              end
              psnap_pkg::MODE_LOAD: begin
                state <= ST_PAGE;
              end
              default: begin
                state <= ST_HOLD;
              end
            endcase
          end
        end
        ST_PAGE: begin
          top   <= page_rdata;
          state <= ST_NODE;
        end
        ST_NODE: begin
          top_val <= node_rdata.value;
          top_par <= node_rdata.parent;
          state   <= ST_HOLD;
        end
        ST_HOLD: begin
          if (hold_load) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      m_tdata <= {{(psnap_pkg::OUT_DATA_W - psnap_pkg::VAL_W){1'b0}}, top_val};
      m_tuser <= {full, (top == '0)};
    end
  end

endmodule
